// ----- src/isp_pkg.sv -----
package isp_pkg;

  // Input sample format
  localparam int SAMPLE_W    = 12;
  localparam int SAMPLE_BITS = 12;
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = SAMPLE_W'((64'd1 << SAMPLE_BITS) - 64'd1);

  // Normalized channel, 0..100
  localparam int NORM_W = 7;
  localparam logic [NORM_W-1:0] NORM_SCALE    = 7'd100;
  localparam logic [NORM_W-1:0] SIDE_STRONG   = 7'd40;
  localparam logic [NORM_W-1:0] CENTER_STRONG = 7'd24;
  localparam logic [NORM_W:0]   LOCK_DELTA    = 8'd13;

  // Error shaping: e = (r^3 + 2500 r) / 12500
  localparam logic [11:0] CUBE_LIN  = 12'd2500;

  // t / 12500 == (t * 1374390) >> 34 for every 21-bit t
  localparam int          ERR_SHIFT  = 34;
  localparam int          ERR_PROD_W = 42;
  localparam logic [20:0] ERR_RECIP  = 21'd1374390;

  // x / 10 == (x * 52429) >> 19 for every 16-bit x
  localparam int          RECIP10_SHIFT = 19;
  localparam logic [15:0] RECIP10       = 16'd52429;

  // Shared divider geometry
  localparam int DIV_NW = 21;
  localparam int DIV_DW = 14;
  localparam int DIV_QW = 7;
  localparam int DIV_CW = $clog2(DIV_QW);

  // Servo duty arithmetic
  localparam int SERVO_LEFT_LIMIT  = 170;
  localparam int SERVO_RIGHT_LIMIT = 245;
  localparam int DUTY_W = 15;
  localparam int DIST_W = DUTY_W + 1;
  localparam logic signed [DUTY_W-1:0] DUTY_LEFT  = DUTY_W'(SERVO_LEFT_LIMIT);
  localparam logic signed [DUTY_W-1:0] DUTY_RIGHT = DUTY_W'(SERVO_RIGHT_LIMIT);
  localparam logic signed [DIST_W-1:0] SHARP_BAND  = 25;
  localparam logic signed [DIST_W-1:0] GENTLE_BAND = 20;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 12;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SENSOR_MIN   = 4'd0,
    REG_SENSOR_MAX   = 4'd1,
    REG_SERVO_CENTER = 4'd2,
    REG_STEER_KP     = 4'd3,
    REG_STEER_KD     = 4'd4,
    REG_SPEED_HIGH   = 4'd5,
    REG_SPEED_MID    = 4'd6,
    REG_SPEED_LOW    = 4'd7
  } cfg_reg_e;

  typedef enum logic [1:0] {
    CLS_STRAIGHT = 2'd0,
    CLS_GENTLE   = 2'd1,
    CLS_SHARP    = 2'd2
  } curve_class_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_NORM_GO,
    ST_NORM_WAIT,
    ST_RATIO_GO,
    ST_RATIO_WAIT,
    ST_CUBE_SQ,
    ST_CUBE_SUM,
    ST_ERR_MUL,
    ST_ERR_SIGN,
    ST_PD_MUL,
    ST_PD_DIV,
    ST_DUTY
  } core_state_e;

  typedef struct packed {
    logic [11:0] sensor_min;
    logic [11:0] sensor_max;
    logic [7:0]  servo_center;
    logic [7:0]  steer_kp;
    logic [7:0]  steer_kd;
    logic [9:0]  speed_high;
    logic [9:0]  speed_mid;
    logic [9:0]  speed_low;
  } cfg_t;

  typedef struct packed {
    logic [SAMPLE_W-1:0] sample_center;
    logic [SAMPLE_W-1:0] sample_right;
    logic [SAMPLE_W-1:0] sample_left;
  } samples_t;

  typedef struct packed {
    logic [NORM_W-1:0] norm_center;
    logic [NORM_W-1:0] norm_right;
    logic [NORM_W-1:0] norm_left;
    logic              tracking;
    logic [7:0]        steer_error;
    curve_class_e      curve_class;
    logic [9:0]        speed_target;
    logic [11:0]       pwm_compare;
    logic [7:0]        servo_duty;
  } result_t;

endpackage

// ----- src/isp_front.sv -----
// Input side: masks samples to the ADC width and holds them in a
// two-entry queue so the back end can stall on its own.
module isp_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  isp_pkg::samples_t in_item_i,
  output logic              head_valid_o,
  output isp_pkg::samples_t head_o,
  input  logic              pop_i
);

  isp_pkg::samples_t entry_q [2];
  isp_pkg::samples_t masked;
  logic              wr_ptr_q, rd_ptr_q;
  logic [1:0]        count_q;
  logic              push, pop;

  assign in_ready_o   = (count_q != 2'd2);
  assign head_valid_o = (count_q != 2'd0);
  assign head_o       = entry_q[rd_ptr_q];
  assign push         = in_valid_i && in_ready_o;
  assign pop          = pop_i && head_valid_o;

  // Keep only the live ADC bits
  always_comb begin
    masked.sample_left   = in_item_i.sample_left   & isp_pkg::SAMPLE_MASK;
    masked.sample_right  = in_item_i.sample_right  & isp_pkg::SAMPLE_MASK;
    masked.sample_center = in_item_i.sample_center & isp_pkg::SAMPLE_MASK;
  end

  // Queue storage
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= masked;
    end
  end

  // Queue pointers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push) wr_ptr_q <= ~wr_ptr_q;
      if (pop)  rd_ptr_q <= ~rd_ptr_q;
      case ({push, pop})
        2'b10:   count_q <= count_q + 2'd1;
        2'b01:   count_q <= count_q - 2'd1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ----- src/isp_div.sv -----
// Restoring divider, one quotient bit per cycle, MSB first.
// The caller guarantees num < den << DIV_QW.
module isp_div (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [isp_pkg::DIV_NW-1:0] num_i,
  input  logic [isp_pkg::DIV_DW-1:0] den_i,
  output logic                       done_o,
  output logic [isp_pkg::DIV_QW-1:0] quot_o
);

  localparam logic [isp_pkg::DIV_CW-1:0] LAST = isp_pkg::DIV_CW'(isp_pkg::DIV_QW - 1);

  logic [isp_pkg::DIV_NW-1:0] rem_q, dsh_q;
  logic [isp_pkg::DIV_QW-1:0] quot_q;
  logic [isp_pkg::DIV_CW-1:0] cnt_q;
  logic                       busy_q, done_q;
  logic                       ge;

  assign ge     = (rem_q >= dsh_q);
  assign done_o = done_q;
  assign quot_o = quot_q;

  // Datapath
  always_ff @(posedge clk_i) begin
    if (start_i && !busy_q) begin
      rem_q  <= num_i;
      dsh_q  <= isp_pkg::DIV_NW'({den_i, {(isp_pkg::DIV_QW-1){1'b0}}});
      quot_q <= '0;
    end else if (busy_q) begin
      if (ge) rem_q <= rem_q - dsh_q;
      dsh_q  <= dsh_q >> 1;
      quot_q <= {quot_q[isp_pkg::DIV_QW-2:0], ge};
    end
  end

  // Control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i && !busy_q) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

endmodule

// ----- src/isp_core.sv -----
// Back end: sequencer around one shared divider. Normalizes the three
// channels, forms the shaped error and PD duty, and fills the output register.
module isp_core (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  isp_pkg::cfg_t     cfg_i,
  input  logic              head_valid_i,
  input  isp_pkg::samples_t head_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output isp_pkg::result_t  res_o
);

  localparam int NW = isp_pkg::NORM_W;
  localparam int DW = isp_pkg::DUTY_W;

  isp_pkg::core_state_e state_q, state_d;

  // Working registers
  isp_pkg::samples_t     raw_q;
  logic [1:0]            ch_q;
  logic [NW-1:0]         nl_q, nr_q, nc_q;
  logic                  rneg_q;
  logic [NW-1:0]         rmag_q;
  logic [13:0]           sq_q;
  logic [isp_pkg::DIV_NW-1:0] t_q;
  logic [isp_pkg::ERR_PROD_W-1:0] eprod_q;
  logic signed [7:0]     e_q;
  logic [15:0]           pmag_q, dmag_q;
  logic                  pneg_q, dneg_q;
  logic [12:0]           p_q, d_q;

  // Architectural state
  logic                  turn_left_q, locked_q;
  logic signed [7:0]     prev_err_q;

  // Output register
  logic                  out_valid_q;
  isp_pkg::result_t      res_q;

  // Divider hookup
  logic                       div_start, div_done;
  logic [isp_pkg::DIV_NW-1:0] div_num;
  logic [isp_pkg::DIV_DW-1:0] div_den;
  logic [isp_pkg::DIV_QW-1:0] div_quot;

  isp_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  // Channel clamp and scale numerator
  logic [11:0] sel_raw, clamped, offset, span;
  logic        span_empty;
  logic [18:0] norm_num;

  always_comb begin
    case (ch_q)
      2'd0:    sel_raw = raw_q.sample_left;
      2'd1:    sel_raw = raw_q.sample_right;
      default: sel_raw = raw_q.sample_center;
    endcase
    clamped = sel_raw;
    if (clamped > cfg_i.sensor_max) clamped = cfg_i.sensor_max;
    if (clamped < cfg_i.sensor_min) clamped = cfg_i.sensor_min;
    offset     = clamped - cfg_i.sensor_min;
    span       = cfg_i.sensor_max - cfg_i.sensor_min;
    span_empty = (cfg_i.sensor_max <= cfg_i.sensor_min);
    norm_num   = 19'(offset) * 19'(isp_pkg::NORM_SCALE);
  end

  // Left/right difference and sum
  logic [NW:0]   diff8, sum8;
  logic          diff_neg;
  logic [NW-1:0] diff_mag;
  logic [13:0]   ratio_num;

  always_comb begin
    diff8     = {1'b0, nr_q} - {1'b0, nl_q};
    sum8      = {1'b0, nr_q} + {1'b0, nl_q};
    diff_neg  = diff8[NW];
    diff_mag  = diff_neg ? NW'(-diff8) : diff8[NW-1:0];
    ratio_num = 14'(diff_mag) * 14'(isp_pkg::NORM_SCALE);
  end

  // Cubic shaping terms
  logic [isp_pkg::DIV_NW-1:0] cube_sum;
  assign cube_sum = isp_pkg::DIV_NW'(sq_q) * isp_pkg::DIV_NW'(rmag_q)
                  + isp_pkg::DIV_NW'(rmag_q) * isp_pkg::DIV_NW'(isp_pkg::CUBE_LIN);

  // Error magnitude from the reciprocal product
  logic [NW-1:0] e_quot;
  assign e_quot = eprod_q[isp_pkg::ERR_SHIFT +: NW];

  // PD magnitudes
  logic signed [8:0] de9;
  logic [7:0]        de_mag;
  logic [NW-1:0]     e_mag;
  logic [31:0]       p_prod, d_prod;

  always_comb begin
    de9    = {e_q[7], e_q} - {prev_err_q[7], prev_err_q};
    de_mag = de9[8] ? 8'(-de9) : de9[7:0];
    e_mag  = e_q[7] ? NW'(-e_q) : e_q[NW-1:0];
    p_prod = 32'(pmag_q) * 32'(isp_pkg::RECIP10);
    d_prod = 32'(dmag_q) * 32'(isp_pkg::RECIP10);
  end

  // Direction latch, duty clamp and curve class
  logic                     tracking, left_set, right_set, latch_n, lock_n;
  logic signed [DW-1:0]     p_s, d_s, duty_raw, duty_pre, duty_c1, duty_c2;
  logic signed [isp_pkg::DIST_W-1:0] duty_dist;
  logic [17:0]              pwm_full;
  isp_pkg::result_t         res_n;
  logic                     out_free;

  always_comb begin
    tracking  = (nl_q >= isp_pkg::SIDE_STRONG) || (nc_q > isp_pkg::CENTER_STRONG)
             || (nr_q >= isp_pkg::SIDE_STRONG);
    left_set  = !locked_q && ({1'b0, nl_q} >= {1'b0, nr_q} + isp_pkg::LOCK_DELTA);
    right_set = !locked_q && !left_set
             && ({1'b0, nr_q} >= {1'b0, nl_q} + isp_pkg::LOCK_DELTA);
    latch_n   = left_set ? 1'b1 : (right_set ? 1'b0 : turn_left_q);
    lock_n    = tracking ? 1'b0 : (locked_q || left_set || right_set);

    p_s      = pneg_q ? -$signed({2'b00, p_q}) : $signed({2'b00, p_q});
    d_s      = dneg_q ? -$signed({2'b00, d_q}) : $signed({2'b00, d_q});
    duty_raw = $signed({7'd0, cfg_i.servo_center}) + p_s + d_s;
    duty_pre = tracking ? duty_raw
             : (latch_n ? isp_pkg::DUTY_LEFT : isp_pkg::DUTY_RIGHT);
    duty_c1  = (duty_pre <= isp_pkg::DUTY_LEFT) ? isp_pkg::DUTY_LEFT : duty_pre;
    duty_c2  = (duty_c1 >= isp_pkg::DUTY_RIGHT) ? isp_pkg::DUTY_RIGHT : duty_c1;
    duty_dist = $signed({duty_c2[DW-1], duty_c2}) - $signed({8'd0, cfg_i.servo_center});
    pwm_full = 18'($unsigned(duty_c2)) * 18'd10;

    res_n.servo_duty  = duty_c2[7:0];
    res_n.pwm_compare = pwm_full[11:0];
    if (duty_dist > isp_pkg::SHARP_BAND || duty_dist < -isp_pkg::SHARP_BAND) begin
      res_n.curve_class  = isp_pkg::CLS_SHARP;
      res_n.speed_target = cfg_i.speed_low;
    end else if (duty_dist > isp_pkg::GENTLE_BAND || duty_dist < -isp_pkg::GENTLE_BAND) begin
      res_n.curve_class  = isp_pkg::CLS_GENTLE;
      res_n.speed_target = cfg_i.speed_mid;
    end else begin
      res_n.curve_class  = isp_pkg::CLS_STRAIGHT;
      res_n.speed_target = cfg_i.speed_high;
    end
    res_n.steer_error = tracking ? e_q : prev_err_q;
    res_n.tracking    = tracking;
    res_n.norm_left   = nl_q;
    res_n.norm_right  = nr_q;
    res_n.norm_center = nc_q;

    out_free = !out_valid_q || out_ready_i;
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      isp_pkg::ST_IDLE:       if (head_valid_i) state_d = isp_pkg::ST_NORM_GO;
      isp_pkg::ST_NORM_GO:    state_d = isp_pkg::ST_NORM_WAIT;
      isp_pkg::ST_NORM_WAIT:  if (div_done) begin
        state_d = (ch_q == 2'd2) ? isp_pkg::ST_RATIO_GO : isp_pkg::ST_NORM_GO;
      end
      isp_pkg::ST_RATIO_GO:   state_d = isp_pkg::ST_RATIO_WAIT;
      isp_pkg::ST_RATIO_WAIT: if (div_done) state_d = isp_pkg::ST_CUBE_SQ;
      isp_pkg::ST_CUBE_SQ:    state_d = isp_pkg::ST_CUBE_SUM;
      isp_pkg::ST_CUBE_SUM:   state_d = isp_pkg::ST_ERR_MUL;
      isp_pkg::ST_ERR_MUL:    state_d = isp_pkg::ST_ERR_SIGN;
      isp_pkg::ST_ERR_SIGN:   state_d = isp_pkg::ST_PD_MUL;
      isp_pkg::ST_PD_MUL:     state_d = isp_pkg::ST_PD_DIV;
      isp_pkg::ST_PD_DIV:     state_d = isp_pkg::ST_DUTY;
      isp_pkg::ST_DUTY:       if (out_free) state_d = isp_pkg::ST_IDLE;
      default:                state_d = isp_pkg::ST_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    pop_o     = 1'b0;
    div_start = 1'b0;
    div_num   = isp_pkg::DIV_NW'(norm_num);
    div_den   = isp_pkg::DIV_DW'(span);
    case (state_q)
      isp_pkg::ST_IDLE:     pop_o = head_valid_i;
      isp_pkg::ST_NORM_GO:  div_start = 1'b1;
      isp_pkg::ST_RATIO_GO: begin
        div_start = 1'b1;
        div_num   = isp_pkg::DIV_NW'(ratio_num);
        div_den   = isp_pkg::DIV_DW'(sum8);
      end
      default: begin
        pop_o     = 1'b0;
        div_start = 1'b0;
      end
    endcase
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      isp_pkg::ST_IDLE: begin
        raw_q <= head_i;
        ch_q  <= 2'd0;
      end
      isp_pkg::ST_NORM_WAIT: if (div_done) begin
        case (ch_q)
          2'd0:    nl_q <= span_empty ? '0 : div_quot;
          2'd1:    nr_q <= span_empty ? '0 : div_quot;
          default: nc_q <= span_empty ? '0 : div_quot;
        endcase
        ch_q <= ch_q + 2'd1;
      end
      isp_pkg::ST_RATIO_WAIT: if (div_done) begin
        rneg_q <= diff_neg;
        rmag_q <= (sum8 == '0) ? '0 : div_quot;
      end
      isp_pkg::ST_CUBE_SQ:  sq_q <= 14'(rmag_q) * 14'(rmag_q);
      isp_pkg::ST_CUBE_SUM: t_q <= cube_sum;
      isp_pkg::ST_ERR_MUL: begin
        eprod_q <= isp_pkg::ERR_PROD_W'(t_q) * isp_pkg::ERR_PROD_W'(isp_pkg::ERR_RECIP);
      end
      isp_pkg::ST_ERR_SIGN: begin
        e_q <= rneg_q ? -$signed({1'b0, e_quot}) : $signed({1'b0, e_quot});
      end
      isp_pkg::ST_PD_MUL: begin
        pmag_q <= 16'(cfg_i.steer_kp) * 16'(e_mag);
        dmag_q <= 16'(cfg_i.steer_kd) * 16'(de_mag);
        pneg_q <= e_q[7];
        dneg_q <= de9[8];
      end
      isp_pkg::ST_PD_DIV: begin
        p_q <= 13'(p_prod >> isp_pkg::RECIP10_SHIFT);
        d_q <= 13'(d_prod >> isp_pkg::RECIP10_SHIFT);
      end
      isp_pkg::ST_DUTY: if (out_free) res_q <= res_n;
      default: ;
    endcase
  end

  // Control and steering state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= isp_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      turn_left_q <= 1'b0;
      locked_q    <= 1'b0;
      prev_err_q  <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == isp_pkg::ST_DUTY && out_free) begin
        out_valid_q <= 1'b1;
        turn_left_q <= latch_n;
        locked_q    <= lock_n;
        if (tracking) prev_err_q <= e_q;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign res_o       = res_q;

endmodule

// ----- src/inductor_steering_pd.sv -----
// The back end works on one item at a time: each item takes four passes (three channels,
// ratio) through the shared divider plus eight sequencer steps, and the next item
// is popped only once the result has gone into the output register.
// A two-entry input queue and the output register let either side stall alone.
// Reset (rst_ni, async, active low) clears control, the direction latch and the
// held error, and loads the configuration registers with their defaults.
module inductor_steering_pd (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // Input items
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [39:0]                    s_axis_tdata,  // sample_left, sample_right, sample_center
  // Result items
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // servo_duty, pwm_compare, speed_target, curve_class, steer_error, tracking,
  // norm_left, norm_right, norm_center
  output logic [63:0]                    m_axis_tdata,
  // Configuration writes
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [isp_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [isp_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  isp_pkg::cfg_t     cfg_q;
  isp_pkg::samples_t in_item, head;
  isp_pkg::result_t  res;
  logic              head_valid, pop;

  assign cfg_ready_o = 1'b1;

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sensor_min   <= 12'd0;
      cfg_q.sensor_max   <= 12'd2400;
      cfg_q.servo_center <= 8'd210;
      cfg_q.steer_kp     <= 8'd10;
      cfg_q.steer_kd     <= 8'd60;
      cfg_q.speed_high   <= 10'd330;
      cfg_q.speed_mid    <= 10'd280;
      cfg_q.speed_low    <= 10'd240;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (isp_pkg::cfg_reg_e'(cfg_index_i))
        isp_pkg::REG_SENSOR_MIN:   cfg_q.sensor_min   <= cfg_data_i[11:0];
        isp_pkg::REG_SENSOR_MAX:   cfg_q.sensor_max   <= cfg_data_i[11:0];
        isp_pkg::REG_SERVO_CENTER: cfg_q.servo_center <= cfg_data_i[7:0];
        isp_pkg::REG_STEER_KP:     cfg_q.steer_kp     <= cfg_data_i[7:0];
        isp_pkg::REG_STEER_KD:     cfg_q.steer_kd     <= cfg_data_i[7:0];
        isp_pkg::REG_SPEED_HIGH:   cfg_q.speed_high   <= cfg_data_i[9:0];
        isp_pkg::REG_SPEED_MID:    cfg_q.speed_mid    <= cfg_data_i[9:0];
        isp_pkg::REG_SPEED_LOW:    cfg_q.speed_low    <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  // Unpack input item
  assign in_item.sample_left   = s_axis_tdata[11:0];
  assign in_item.sample_right  = s_axis_tdata[23:12];
  assign in_item.sample_center = s_axis_tdata[35:24];

  isp_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_item_i    (in_item),
    .head_valid_o (head_valid),
    .head_o       (head),
    .pop_i        (pop)
  );

  isp_core u_core (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .head_valid_i (head_valid),
    .head_i       (head),
    .pop_o        (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  // Pack result item
  assign m_axis_tdata = {2'b00, res.norm_center, res.norm_right, res.norm_left,
                         res.tracking, res.steer_error, res.curve_class,
                         res.speed_target, res.pwm_compare, res.servo_duty};

`ifndef SYNTHESIS
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (res.servo_duty >= 8'(isp_pkg::SERVO_LEFT_LIMIT)
                    && res.servo_duty <= 8'(isp_pkg::SERVO_RIGHT_LIMIT)))
    else $error("servo duty outside the servo limits");

  a_full_lock: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && !res.tracking) |->
      (res.servo_duty == 8'(isp_pkg::SERVO_LEFT_LIMIT)
    || res.servo_duty == 8'(isp_pkg::SERVO_RIGHT_LIMIT)))
    else $error("lost-line result not at full lock");

  a_pop_has_head: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> head_valid)
    else $error("back end popped an empty queue");
`endif

endmodule

// ----- bench/testbench.sv -----
module testbench;
  import isp_pkg::*;

  // Decision levels of the steering law
  localparam int LOCK_GAP     = 13;
  localparam int SIDE_LEVEL   = 40;
  localparam int CENTER_LEVEL = 24;
  localparam int SHARP_LIMIT  = 25;
  localparam int GENTLE_LIMIT = 20;
  localparam int CUBE_GAIN    = 2500;
  localparam int ERROR_DIV    = 12500;

  // Bench timing
  localparam int MAX_WAIT       = 16;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int LINGER_CYCLES  = 80;
  localparam int REG_COUNT      = 8;
  localparam int PHASES         = 8;
  localparam int PHASE_ITEMS    = 250;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [39:0]           s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [63:0]           m_axis_tdata;
  logic                  cfg_valid_i = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;

  // Shadow of the controller: registers, direction latch, held error
  cfg_t    steer_cfg;
  bit      turn_left;
  bit      dir_locked;
  int      held_error;

  result_t pending_steering[$];
  result_t want, got;
  int      error_count = 0;
  int      ready_hold = 0;
  int      idle_cycles = 0;
  bit      back_to_back = 1'b0;

  inductor_steering_pd dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  task automatic reset_model();
    steer_cfg.sensor_min   = 12'd0;
    steer_cfg.sensor_max   = 12'd2400;
    steer_cfg.servo_center = 8'd210;
    steer_cfg.steer_kp     = 8'd10;
    steer_cfg.steer_kd     = 8'd60;
    steer_cfg.speed_high   = 10'd330;
    steer_cfg.speed_mid    = 10'd280;
    steer_cfg.speed_low    = 10'd240;
    turn_left  = 1'b0;
    dir_locked = 1'b0;
    held_error = 0;
  endtask

  // Clamp a raw sample to the sensor window and scale to 0..100
  function automatic int norm_channel(logic [SAMPLE_W-1:0] raw);
    int v, lo, hi;
    v  = int'(raw & SAMPLE_MASK);
    lo = int'(steer_cfg.sensor_min);
    hi = int'(steer_cfg.sensor_max);
    if (hi <= lo) return 0;
    if (v > hi) v = hi;
    if (v < lo) v = lo;
    return (100 * (v - lo)) / (hi - lo);
  endfunction

  // Expected servo, speed and channel outputs for one sample set
  function automatic result_t predict_steering(logic [SAMPLE_W-1:0] left, right, center);
    int nl, nr, nc, duty, deviation, sum, ratio, err, prev, mid;
    bit on_line;
    result_t res;
    nl  = norm_channel(left);
    nr  = norm_channel(right);
    nc  = norm_channel(center);
    mid = int'(steer_cfg.servo_center);
    on_line = 1'b0;
    if (nl - nr >= LOCK_GAP && !dir_locked) begin
      turn_left  = 1'b1;
      dir_locked = 1'b1;
    end
    if (nr - nl >= LOCK_GAP && !dir_locked) begin
      turn_left  = 1'b0;
      dir_locked = 1'b1;
    end
    duty = turn_left ? SERVO_LEFT_LIMIT : SERVO_RIGHT_LIMIT;

    // PD branch while any channel still sees the wire
    if (nl >= SIDE_LEVEL || nc > CENTER_LEVEL || nr >= SIDE_LEVEL) begin
      on_line    = 1'b1;
      dir_locked = 1'b0;
      sum   = nl + nr;
      ratio = (sum != 0) ? (100 * (nr - nl)) / sum : 0;
      err   = (ratio * ratio * ratio + CUBE_GAIN * ratio) / ERROR_DIV;
      prev  = held_error;
      held_error = err;
      duty = mid + (int'(steer_cfg.steer_kp) * err) / 10
                 + (int'(steer_cfg.steer_kd) * (err - prev)) / 10;
    end

    if (duty <= SERVO_LEFT_LIMIT) duty = SERVO_LEFT_LIMIT;
    if (duty >= SERVO_RIGHT_LIMIT) duty = SERVO_RIGHT_LIMIT;

    deviation = duty - mid;
    if (deviation > SHARP_LIMIT || deviation < -SHARP_LIMIT) begin
      res.curve_class  = CLS_SHARP;
      res.speed_target = steer_cfg.speed_low;
    end else if (deviation > GENTLE_LIMIT || deviation < -GENTLE_LIMIT) begin
      res.curve_class  = CLS_GENTLE;
      res.speed_target = steer_cfg.speed_mid;
    end else begin
      res.curve_class  = CLS_STRAIGHT;
      res.speed_target = steer_cfg.speed_high;
    end
    res.servo_duty  = 8'(duty);
    res.pwm_compare = 12'(duty * 10);
    res.steer_error = 8'(held_error);
    res.tracking    = on_line;
    res.norm_left   = NORM_W'(nl);
    res.norm_right  = NORM_W'(nr);
    res.norm_center = NORM_W'(nc);
    return res;
  endfunction

  // Raw sample sitting at a given percentage of the current sensor window
  function automatic logic [SAMPLE_W-1:0] sample_at(int pct);
    int lo, span;
    lo   = int'(steer_cfg.sensor_min);
    span = int'(steer_cfg.sensor_max) - lo;
    if (span <= 0) return SAMPLE_W'($urandom);
    return SAMPLE_W'(lo + (span * pct) / 100);
  endfunction

  task automatic compare_field(string name, int expv, int actv);
    if (expv != actv) begin
      $error("%s mismatch: expected %0d, actual %0d", name, expv, actv);
      error_count++;
    end
  endtask

  // Stop the input stream and wait until every predicted result is back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    while (pending_steering.size() != 0) @(posedge clk_i);
  endtask

  // One input item, with a random lead-in gap unless back_to_back is set
  task automatic send_sample(logic [SAMPLE_W-1:0] left, right, center);
    int gap;
    samples_t item;
    gap = back_to_back ? 0 : $urandom_range(0, MAX_WAIT);
    cfg_valid_i <= 1'b0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    item.sample_left   = left;
    item.sample_right  = right;
    item.sample_center = center;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {4'b0, item};
    do @(posedge clk_i); while (!s_axis_tready);
    pending_steering.push_back(predict_steering(left, right, center));
  endtask

  // Register write while idle; bits above a register's width are random
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [11:0] value);
    logic [CFG_DATA_W-1:0] data;
    drain_results();
    data = CFG_DATA_W'($urandom);
    case (index)
      REG_SENSOR_MIN, REG_SENSOR_MAX: data = value;
      REG_SERVO_CENTER, REG_STEER_KP, REG_STEER_KD: data[7:0] = value[7:0];
      REG_SPEED_HIGH, REG_SPEED_MID, REG_SPEED_LOW: data[9:0] = value[9:0];
      default: ;
    endcase
    cfg_valid_i <= 1'b1;
    cfg_index_i <= index;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (index)
      REG_SENSOR_MIN:   steer_cfg.sensor_min   = data;
      REG_SENSOR_MAX:   steer_cfg.sensor_max   = data;
      REG_SERVO_CENTER: steer_cfg.servo_center = data[7:0];
      REG_STEER_KP:     steer_cfg.steer_kp     = data[7:0];
      REG_STEER_KD:     steer_cfg.steer_kd     = data[7:0];
      REG_SPEED_HIGH:   steer_cfg.speed_high   = data[9:0];
      REG_SPEED_MID:    steer_cfg.speed_mid    = data[9:0];
      REG_SPEED_LOW:    steer_cfg.speed_low    = data[9:0];
      default: ;
    endcase
  endtask

  task automatic write_all(int lo, int hi, int mid, int kp, int kd,
                           int fast, int medium_speed, int slow);
    write_reg(REG_SENSOR_MIN, 12'(lo));
    write_reg(REG_SENSOR_MAX, 12'(hi));
    write_reg(REG_SERVO_CENTER, 12'(mid));
    write_reg(REG_STEER_KP, 12'(kp));
    write_reg(REG_STEER_KD, 12'(kd));
    write_reg(REG_SPEED_HIGH, 12'(fast));
    write_reg(REG_SPEED_MID, 12'(medium_speed));
    write_reg(REG_SPEED_LOW, 12'(slow));
  endtask

  // Lost signal: latch a side, hold it while locked, release on tracking
  task automatic test_lost_signal_latch();
    send_sample(12'd0, 12'd0, 12'd0);
    send_sample(12'd900, 12'd0, 12'd0);
    send_sample(12'd0, 12'd0, 12'd0);
    send_sample(12'd0, 12'd900, 12'd0);
    send_sample(12'd2400, 12'd2400, 12'd0);
    send_sample(12'd0, 12'd900, 12'd0);
  endtask

  // Full-scale samples, zero left+right sum, and the strength thresholds
  task automatic test_full_scale();
    send_sample(12'hFFF, 12'hFFF, 12'hFFF);
    send_sample(12'hFFF, 12'd0, 12'd0);
    send_sample(12'd0, 12'hFFF, 12'd0);
    send_sample(12'd0, 12'd0, 12'hFFF);
    send_sample(12'd0, 12'd0, 12'd600);
    send_sample(12'd0, 12'd0, 12'd576);
    send_sample(12'd960, 12'd0, 12'd0);
  endtask

  // Window with max at or below min: every channel reads zero
  task automatic test_empty_span();
    write_reg(REG_SENSOR_MIN, 12'd2000);
    write_reg(REG_SENSOR_MAX, 12'd1000);
    send_sample(12'hFFF, 12'd0, 12'd2500);
    send_sample(12'd1500, 12'd1500, 12'd1500);
    write_reg(REG_SENSOR_MAX, 12'd2000);
    send_sample(12'd2000, 12'hFFF, 12'd0);
  endtask

  // Largest gains, then zero gains with the center at the right limit, drive the duty into both servo limits
  task automatic test_gain_extremes();
    write_all(0, 4095, 170, 255, 255, 1023, 0, 511);
    send_sample(12'hFFF, 12'd0, 12'd0);
    send_sample(12'd0, 12'hFFF, 12'd0);
    send_sample(12'd2000, 12'd2100, 12'd0);
    write_all(4094, 4095, 245, 0, 0, 0, 1023, 1023);
    send_sample(12'hFFF, 12'hFFE, 12'd0);
    send_sample(12'd0, 12'hFFF, 12'd0);
  endtask

  // Writes to indexes past the register file must change nothing
  task automatic test_unknown_index();
    write_all(0, 2400, 210, 10, 60, 330, 280, 240);
    write_reg(CFG_IDX_W'($urandom_range(REG_COUNT, (1 << CFG_IDX_W) - 1)), 12'($urandom));
    write_reg(CFG_IDX_W'((1 << CFG_IDX_W) - 1), 12'($urandom));
    send_sample(12'd2400, 12'd0, 12'd1200);
    send_sample(12'd300, 12'd1800, 12'd0);
  endtask

  // Phases of random traffic, each under its own register setting
  task automatic test_random_traffic();
    int phase, n, kind, lo;
    logic [SAMPLE_W-1:0] left, right, center;
    for (phase = 0; phase < PHASES; phase++) begin
      case (phase)
        0: ;
        1: write_all(0, 4095, 245, 255, 255, 1023, 0, 511);
        2: write_all(4094, 4095, 170, 0, 0, 0, 1023, 1);
        3: write_all(0, 2400, 210, 10, 60, 330, 280, 240);
        default: begin
          lo = $urandom_range(0, 3000);
          write_all(lo, $urandom_range(lo + 1, 4095), $urandom_range(170, 245),
                    $urandom_range(0, 255), $urandom_range(0, 255),
                    $urandom_range(0, 1023), $urandom_range(0, 1023),
                    $urandom_range(0, 1023));
        end
      endcase
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (n % 50 == 0) back_to_back = ($urandom_range(0, 3) == 0);
        if (n == PHASE_ITEMS / 2) drain_results();
        kind = $urandom_range(0, 9);
        if (kind < 3) begin
          // raw noise over the whole input range
          left   = SAMPLE_W'($urandom);
          right  = SAMPLE_W'($urandom);
          center = SAMPLE_W'($urandom);
        end else if (kind < 6) begin
          // weak signal on every channel: full-lock path and side latch
          left   = sample_at($urandom_range(0, SIDE_LEVEL - 1));
          right  = sample_at($urandom_range(0, SIDE_LEVEL - 1));
          center = sample_at($urandom_range(0, CENTER_LEVEL));
        end else begin
          // on the line: PD path across the whole ratio range
          left   = sample_at($urandom_range(0, 100));
          right  = sample_at($urandom_range(SIDE_LEVEL, 100));
          center = sample_at($urandom_range(0, 100));
          if ($urandom_range(0, 1)) {left, right} = {right, left};
        end
        send_sample(left, right, center);
      end
    end
    back_to_back = 1'b0;
  endtask

  // Result checker with random back-pressure
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = result_t'(m_axis_tdata[$bits(result_t)-1:0]);
      if (pending_steering.size() == 0) begin
        $error("result with no pending prediction: %h", m_axis_tdata);
        error_count++;
      end else begin
        want = pending_steering.pop_front();
        compare_field("servo_duty", want.servo_duty, got.servo_duty);
        compare_field("pwm_compare", want.pwm_compare, got.pwm_compare);
        compare_field("speed_target", want.speed_target, got.speed_target);
        compare_field("curve_class", want.curve_class, got.curve_class);
        compare_field("steer_error", $signed(want.steer_error), $signed(got.steer_error));
        compare_field("tracking", want.tracking, got.tracking);
        compare_field("norm_left", want.norm_left, got.norm_left);
        compare_field("norm_right", want.norm_right, got.norm_right);
        compare_field("norm_center", want.norm_center, got.norm_center);
      end
      ready_hold = back_to_back ? 0 : $urandom_range(0, MAX_WAIT);
    end
    if (ready_hold > 0) begin
      m_axis_tready <= 1'b0;
      ready_hold--;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    reset_model();
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_lost_signal_latch();
    test_full_scale();
    test_empty_span();
    test_gain_extremes();
    test_unknown_index();
    test_random_traffic();
    drain_results();
    cfg_valid_i <= 1'b0;
    repeat (LINGER_CYCLES) @(posedge clk_i);
    if (pending_steering.size() != 0) begin
      $error("%0d predicted results never arrived", pending_steering.size());
      error_count++;
    end
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
